### rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;

    localparam int CMD_W      = 2;
    localparam int PART_W     = 4;
    localparam int VALUE_W    = 16;
    localparam int TOTAL_W    = 20;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int CMP_W = (SIZE_BITS > VALUE_W) ? SIZE_BITS : VALUE_W;
    localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] FIT_FIRST = MODE_W'(0);
    localparam logic [MODE_W-1:0] FIT_BEST  = MODE_W'(1);
    localparam logic [MODE_W-1:0] FIT_WORST = MODE_W'(2);

    localparam logic [CNT_W-1:0] SCAN_MAX = CNT_W'(MAX_PARTITIONS);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } pfa_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } pfa_state_t;

    typedef struct packed {
        logic                 clear;
        logic                 sample;
        logic [MODE_W-1:0]    mode;
        logic [VALUE_W-1:0]   req;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] free;
    } pfa_scan_ctl_t;

    typedef struct packed {
        logic                 fit;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] free;
    } pfa_pick_t;

endpackage

### rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pfa_scan.sv
// ----------------------------------------------------------------------------
// pfa_scan
// Candidate tracker: compares each partition read from the RAM against the
// request and keeps the partition chosen by the current fit mode.
// ----------------------------------------------------------------------------
module pfa_scan (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pfa_pkg::pfa_scan_ctl_t ctl,
    output pfa_pkg::pfa_pick_t    pick
);

    logic                          have_reg;
    logic                          have_next;
    logic [pfa_pkg::IDX_W-1:0]     idx_reg;
    logic [pfa_pkg::IDX_W-1:0]     idx_next;
    logic [pfa_pkg::SIZE_BITS-1:0] free_reg;
    logic [pfa_pkg::SIZE_BITS-1:0] free_next;
    logic                          fits;
    logic                          take;

    assign fits = pfa_pkg::CMP_W'(ctl.free) >= pfa_pkg::CMP_W'(ctl.req);

    always_comb begin
        case (ctl.mode)
            pfa_pkg::FIT_BEST:  take = fits && (!have_reg || (ctl.free < free_reg));
            pfa_pkg::FIT_WORST: take = !have_reg || (ctl.free > free_reg);
            default:            take = fits && !have_reg;
        endcase
    end

    always_comb begin
        have_next = have_reg;
        idx_next  = idx_reg;
        free_next = free_reg;
        if (ctl.clear) begin
            have_next = 1'b0;
        end else if (ctl.sample && take) begin
            have_next = 1'b1;
            idx_next  = ctl.idx;
            free_next = ctl.free;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else begin
            have_reg <= have_next;
        end
        idx_reg  <= idx_next;
        free_reg <= free_next;
    end

    assign pick.fit  = have_reg &&
                       (pfa_pkg::CMP_W'(free_reg) >= pfa_pkg::CMP_W'(ctl.req));
    assign pick.idx  = idx_reg;
    assign pick.free = free_reg;

endmodule

### rtl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Fixed-partition allocator: partition free sizes in a RAM, first, best or
// worst fit chosen by a scan of one read per cycle, fragmentation total.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  s_        s_valid s_ready s_command               in
//            s_partition_index s_size_value
//  m_        m_valid m_ready m_granted               out
//            m_chosen_partition m_leftover m_fragment_total
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data  in
//
//  Allocate: a scan of N = min(partition_count, 16) partitions through the
//  single RAM read port, one partition per cycle, then a commit of the pick.
//  Load, clear and no-op skip the scan and go straight to the result.
//  Reset clears control, fit_mode (first fit), partition_count (16) and the
//  total; partition sizes are undefined until loaded. An output register
//  holds a result while m_ready is low; the next request is still taken.
// ----------------------------------------------------------------------------
module partition_fit_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfa_pkg::CMD_W-1:0]       s_command,
    input  logic [pfa_pkg::PART_W-1:0]      s_partition_index,
    input  logic [pfa_pkg::VALUE_W-1:0]     s_size_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [pfa_pkg::PART_W-1:0]      m_chosen_partition,
    output logic [pfa_pkg::VALUE_W-1:0]     m_leftover,
    output logic [pfa_pkg::TOTAL_W-1:0]     m_fragment_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pfa_pkg::pfa_state_t           state_reg;
    pfa_pkg::pfa_state_t           state_next;
    logic [pfa_pkg::MODE_W-1:0]    fit_mode_reg;
    logic [pfa_pkg::COUNT_W-1:0]   part_count_reg;
    logic [pfa_pkg::VALUE_W-1:0]   req_reg;
    logic [pfa_pkg::VALUE_W-1:0]   req_next;
    logic [pfa_pkg::CNT_W-1:0]     rd_ptr_reg;
    logic [pfa_pkg::CNT_W-1:0]     rd_ptr_next;
    logic                          rvalid_reg;
    logic                          rvalid_next;
    logic [pfa_pkg::IDX_W-1:0]     ridx_reg;
    logic [pfa_pkg::IDX_W-1:0]     ridx_next;
    logic [pfa_pkg::TOTAL_W-1:0]   total_reg;
    logic [pfa_pkg::TOTAL_W-1:0]   total_next;
    logic                          res_granted_reg;
    logic                          res_granted_next;
    logic [pfa_pkg::IDX_W-1:0]     res_idx_reg;
    logic [pfa_pkg::IDX_W-1:0]     res_idx_next;
    logic [pfa_pkg::VALUE_W-1:0]   res_left_reg;
    logic [pfa_pkg::VALUE_W-1:0]   res_left_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          m_granted_reg;
    logic                          m_granted_next;
    logic [pfa_pkg::PART_W-1:0]    m_chosen_reg;
    logic [pfa_pkg::PART_W-1:0]    m_chosen_next;
    logic [pfa_pkg::VALUE_W-1:0]   m_left_reg;
    logic [pfa_pkg::VALUE_W-1:0]   m_left_next;
    logic [pfa_pkg::TOTAL_W-1:0]   m_total_reg;
    logic [pfa_pkg::TOTAL_W-1:0]   m_total_next;

    logic                          accept;
    logic                          out_free;
    pfa_pkg::pfa_cmd_t             cmd_in;
    logic [pfa_pkg::CNT_W-1:0]     limit;
    logic                          load_in_range;
    logic                          ram_we;
    logic [pfa_pkg::IDX_W-1:0]     ram_waddr;
    logic [pfa_pkg::SIZE_BITS-1:0] ram_wdata;
    logic [pfa_pkg::SIZE_BITS-1:0] ram_rdata;
    logic [pfa_pkg::SIZE_BITS-1:0] new_free;
    logic [pfa_pkg::SUM_W-1:0]     sum;
    logic [pfa_pkg::TOTAL_W-1:0]   sat_total;
    pfa_pkg::pfa_scan_ctl_t        scan_ctl;
    pfa_pkg::pfa_pick_t            pick;

    assign s_ready   = (state_reg == pfa_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cmd_in    = pfa_pkg::pfa_cmd_t'(s_command);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign limit = (32'(part_count_reg) > 32'(pfa_pkg::MAX_PARTITIONS)) ?
                   pfa_pkg::SCAN_MAX : pfa_pkg::CNT_W'(part_count_reg);
    assign load_in_range = 32'(s_partition_index) < 32'(pfa_pkg::MAX_PARTITIONS);

    assign new_free  = pick.free - pfa_pkg::SIZE_BITS'(req_reg);
    assign sum       = pfa_pkg::SUM_W'(total_reg) + pfa_pkg::SUM_W'(new_free);
    assign sat_total = (sum > pfa_pkg::SUM_W'(pfa_pkg::TOTAL_MAX)) ?
                       pfa_pkg::TOTAL_MAX : pfa_pkg::TOTAL_W'(sum);

    assign scan_ctl.clear  = accept;
    assign scan_ctl.sample = rvalid_reg;
    assign scan_ctl.mode   = fit_mode_reg;
    assign scan_ctl.req    = req_reg;
    assign scan_ctl.idx    = ridx_reg;
    assign scan_ctl.free   = ram_rdata;

    pfa_ram #(
        .WIDTH (pfa_pkg::SIZE_BITS),
        .DEPTH (pfa_pkg::MAX_PARTITIONS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[pfa_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    pfa_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .pick    (pick)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (cmd_in == pfa_pkg::CMD_ALLOC) ?
                                 pfa_pkg::ST_SCAN : pfa_pkg::ST_RESULT;
                end
            end
            pfa_pkg::ST_SCAN: begin
                if (rd_ptr_reg == limit) begin
                    state_next = pfa_pkg::ST_COMMIT;
                end
            end
            pfa_pkg::ST_COMMIT: begin
                state_next = pfa_pkg::ST_RESULT;
            end
            pfa_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we           = 1'b0;
        ram_waddr        = pfa_pkg::IDX_W'(s_partition_index);
        ram_wdata        = pfa_pkg::SIZE_BITS'(s_size_value);
        req_next         = req_reg;
        rd_ptr_next      = rd_ptr_reg;
        rvalid_next      = 1'b0;
        ridx_next        = ridx_reg;
        total_next       = total_reg;
        res_granted_next = res_granted_reg;
        res_idx_next     = res_idx_reg;
        res_left_next    = res_left_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_granted_next   = m_granted_reg;
        m_chosen_next    = m_chosen_reg;
        m_left_next      = m_left_reg;
        m_total_next     = m_total_reg;
        case (state_reg)
            pfa_pkg::ST_IDLE: begin
                if (accept) begin
                    req_next         = s_size_value;
                    rd_ptr_next      = '0;
                    res_granted_next = 1'b0;
                    res_idx_next     = '0;
                    res_left_next    = '0;
                    case (cmd_in)
                        pfa_pkg::CMD_LOAD:  ram_we     = load_in_range;
                        pfa_pkg::CMD_CLEAR: total_next = '0;
                        default:            ram_we     = 1'b0;
                    endcase
                end
            end
            pfa_pkg::ST_SCAN: begin
                if (rd_ptr_reg != limit) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_ptr_reg[pfa_pkg::IDX_W-1:0];
                end
            end
            pfa_pkg::ST_COMMIT: begin
                if (pick.fit) begin
                    ram_we           = 1'b1;
                    ram_waddr        = pick.idx;
                    ram_wdata        = new_free;
                    total_next       = sat_total;
                    res_granted_next = 1'b1;
                    res_idx_next     = pick.idx;
                    res_left_next    = pfa_pkg::VALUE_W'(new_free);
                end
            end
            pfa_pkg::ST_RESULT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_chosen_next  = pfa_pkg::PART_W'(res_idx_reg);
                    m_left_next    = res_left_reg;
                    m_total_next   = total_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfa_pkg::ST_IDLE;
            fit_mode_reg   <= pfa_pkg::FIT_FIRST;
            part_count_reg <= pfa_pkg::COUNT_W'(pfa_pkg::MAX_PARTITIONS);
            rvalid_reg     <= 1'b0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rvalid_reg  <= rvalid_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pfa_pkg::CFG_FIT_MODE:   fit_mode_reg   <= cfg_data[pfa_pkg::MODE_W-1:0];
                    pfa_pkg::CFG_PART_COUNT: part_count_reg <= cfg_data[pfa_pkg::COUNT_W-1:0];
                    default:                 fit_mode_reg   <= fit_mode_reg;
                endcase
            end
        end
        req_reg         <= req_next;
        rd_ptr_reg      <= rd_ptr_next;
        ridx_reg        <= ridx_next;
        res_granted_reg <= res_granted_next;
        res_idx_reg     <= res_idx_next;
        res_left_reg    <= res_left_next;
        m_granted_reg   <= m_granted_next;
        m_chosen_reg    <= m_chosen_next;
        m_left_reg      <= m_left_next;
        m_total_reg     <= m_total_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_granted          = m_granted_reg;
    assign m_chosen_partition = m_chosen_reg;
    assign m_leftover         = m_left_reg;
    assign m_fragment_total   = m_total_reg;

endmodule

### tb/sv/partition_fit_allocator_test.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator_test
// Self-checking bench for the partition fit allocator. A queue of requests
// feeds a valid/ready driver; a monitor compares every result field against
// a behavioral copy of the allocator (partition sizes, fit mode, partition
// count and fragmentation total) updated as each request is accepted.
// Directed requests cover the corner cases, then randomized phases sweep the
// fit modes and partition counts with random stalls on both channels.
// ----------------------------------------------------------------------------
module partition_fit_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int PHASES      = 11;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [MODE_W-1:0] FIT_SPARE = MODE_W'(3);

    localparam logic [VALUE_W-1:0] SEED_SIZES [MAX_PARTITIONS] = '{
        16'd0, 16'd65535, 16'd100, 16'd50, 16'd200, 16'd100, 16'd1, 16'd65535,
        16'd300, 16'd7, 16'd1000, 16'd2, 16'd40000, 16'd5, 16'd50, 16'd32768
    };
    localparam logic [MODE_W-1:0]     MODE_PLAN  [6] = '{
        FIT_BEST, FIT_FIRST, FIT_WORST, FIT_WORST, FIT_SPARE, FIT_BEST
    };
    localparam logic [CFG_DATA_W-1:0] COUNT_PLAN [6] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16
    };

    typedef struct packed {
        pfa_cmd_t            cmd;
        logic [PART_W-1:0]   part;
        logic [VALUE_W-1:0]  size;
    } alloc_request_t;

    typedef struct packed {
        logic                granted;
        logic [PART_W-1:0]   part;
        logic [VALUE_W-1:0]  left;
        logic [TOTAL_W-1:0]  total;
    } alloc_result_t;

    logic                    aclk              = 1'b0;
    logic                    aresetn           = 1'b0;
    logic                    s_valid           = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_command         = '0;
    logic [PART_W-1:0]       s_partition_index = '0;
    logic [VALUE_W-1:0]      s_size_value      = '0;
    logic                    m_valid;
    logic                    m_ready           = 1'b0;
    logic                    m_granted;
    logic [PART_W-1:0]       m_chosen_partition;
    logic [VALUE_W-1:0]      m_leftover;
    logic [TOTAL_W-1:0]      m_fragment_total;
    logic                    cfg_valid         = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index         = '0;
    logic [CFG_DATA_W-1:0]   cfg_data          = '0;

    alloc_request_t          request_queue[$];
    alloc_result_t           awaited_results[$];
    alloc_request_t          next_req;
    alloc_result_t           got_req;

    logic [SIZE_BITS-1:0]    free_size [MAX_PARTITIONS];
    logic [TOTAL_W-1:0]      frag_total   = '0;
    logic [MODE_W-1:0]       fit_mode_q   = FIT_FIRST;
    logic [CFG_DATA_W-1:0]   part_count_q = CFG_DATA_W'(MAX_PARTITIONS);

    logic                    idle_on      = 1'b1;
    logic                    rx_long_hold = 1'b0;
    logic                    hold_used    = 1'b0;
    int                      hold_left    = 0;
    int                      tx_gap       = 0;
    int                      rx_gap       = 0;
    int                      mismatches   = 0;
    int                      cycle_count  = 0;

    partition_fit_allocator u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_partition_index  (s_partition_index),
        .s_size_value       (s_size_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granted          (m_granted),
        .m_chosen_partition (m_chosen_partition),
        .m_leftover         (m_leftover),
        .m_fragment_total   (m_fragment_total),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic alloc_result_t predict_allocation(pfa_cmd_t cmd,
                                                         logic [PART_W-1:0] idx,
                                                         logic [VALUE_W-1:0] size);
        alloc_result_t    res;
        int               scan_n;
        int               pick;
        logic [TOTAL_W:0] sum;
        res = '0;
        case (cmd)
            CMD_LOAD: free_size[idx] = size;
            CMD_ALLOC: begin
                scan_n = (part_count_q > MAX_PARTITIONS) ? MAX_PARTITIONS :
                         int'(part_count_q);
                pick = -1;
                for (int i = 0; i < scan_n; i++) begin
                    if (fit_mode_q == FIT_BEST) begin
                        if (free_size[i] >= size && (pick < 0 || free_size[i] < free_size[pick]))
                            pick = i;
                    end else if (fit_mode_q == FIT_WORST) begin
                        if (pick < 0 || free_size[i] > free_size[pick])
                            pick = i;
                    end else if (pick < 0 && free_size[i] >= size) begin
                        pick = i;
                    end
                end
                if (pick >= 0 && free_size[pick] >= size) begin
                    free_size[pick] = free_size[pick] - size;
                    res.granted = 1'b1;
                    res.part    = pick[PART_W-1:0];
                    res.left    = free_size[pick];
                    sum = {1'b0, frag_total} + (TOTAL_W+1)'(res.left);
                    frag_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                end
            end
            CMD_CLEAR: frag_total = '0;
            default: ;
        endcase
        res.total = frag_total;
        return res;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_request(pfa_cmd_t cmd, logic [PART_W-1:0] part,
                                logic [VALUE_W-1:0] size);
        request_queue.push_back('{cmd: cmd, part: part, size: size});
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIT_MODE)
            fit_mode_q = data[MODE_W-1:0];
        else
            part_count_q = data;
    endtask

    task automatic drain();
        @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || awaited_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic start_phase(logic [MODE_W-1:0] mode, logic [CFG_DATA_W-1:0] count);
        drain();
        write_register(CFG_FIT_MODE, CFG_DATA_W'(mode));
        write_register(CFG_PART_COUNT, count);
    endtask

    task automatic queue_random(int count, bit heavy);
        int                 roll;
        logic [VALUE_W-1:0] size;
        for (int k = 0; k < count; k++) begin
            roll = int'($urandom_range(0, 99));
            case ($urandom_range(0, 4))
                0:       size = '0;
                1:       size = '1;
                2:       size = VALUE_W'($urandom_range(0, 255));
                3:       size = VALUE_W'($urandom_range(0, 8191));
                default: size = VALUE_W'($urandom);
            endcase
            if (heavy) begin
                if (roll < 30)
                    push_request(CMD_LOAD, PART_W'($urandom_range(0, 15)), '1);
                else
                    push_request(CMD_ALLOC, PART_W'($urandom_range(0, 15)),
                                 VALUE_W'($urandom_range(0, 15)));
            end else if (roll < 30) begin
                push_request(CMD_LOAD, PART_W'($urandom_range(0, 15)), size);
            end else if (roll < 88) begin
                push_request(CMD_ALLOC, PART_W'($urandom_range(0, 15)), size);
            end else if (roll < 95) begin
                push_request(CMD_CLEAR, PART_W'($urandom_range(0, 15)), size);
            end else begin
                push_request(CMD_NOP, PART_W'($urandom_range(0, 15)), size);
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(predict_allocation(pfa_cmd_t'(s_command),
                                                             s_partition_index, s_size_value));
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (idle_on && request_queue.size() != 0
                             && $urandom_range(0, 7) == 0) begin
                    tx_gap  <= int'($urandom_range(0, 5));
                    s_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    next_req = request_queue.pop_front();
                    s_valid           <= 1'b1;
                    s_command         <= next_req.cmd;
                    s_partition_index <= next_req.part;
                    s_size_value      <= next_req.size;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with no request outstanding", $time);
                    mismatches++;
                end else begin
                    got_req = awaited_results.pop_front();
                    check_field("granted", 32'(got_req.granted), 32'(m_granted));
                    check_field("chosen_partition", 32'(got_req.part),
                                32'(m_chosen_partition));
                    check_field("leftover", 32'(got_req.left), 32'(m_leftover));
                    check_field("fragment_total", 32'(got_req.total),
                                32'(m_fragment_total));
                end
            end
            if (rx_long_hold && !hold_used) begin
                hold_used <= 1'b1;
                hold_left <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap  <= rx_gap - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap  <= int'($urandom_range(0, 5));
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every partition before any scan reads it
        for (int p = 0; p < MAX_PARTITIONS; p++)
            push_request(CMD_LOAD, PART_W'(p), SEED_SIZES[p]);
        push_request(CMD_ALLOC, 4'd0, 16'd0);
        push_request(CMD_ALLOC, 4'd0, 16'd65535);
        push_request(CMD_ALLOC, 4'd9, 16'd65535);
        push_request(CMD_ALLOC, 4'd15, 16'd65535);
        push_request(CMD_CLEAR, 4'd3, 16'd1234);
        push_request(CMD_NOP, 4'd15, 16'hFFFF);
        push_request(CMD_ALLOC, 4'd0, 16'd60);

        start_phase(FIT_BEST, 5'd16);
        push_request(CMD_ALLOC, 4'd0, 16'd50);
        start_phase(FIT_WORST, 5'd17);
        push_request(CMD_ALLOC, 4'd0, 16'd1000);
        start_phase(FIT_SPARE, 5'd0);
        push_request(CMD_ALLOC, 4'd0, 16'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 6)
                start_phase(MODE_PLAN[ph], COUNT_PLAN[ph]);
            else
                start_phase(MODE_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 31)));
            if (ph >= PHASES - 2)
                idle_on <= 1'b0;
            if (ph == 1)
                rx_long_hold <= 1'b1;
            queue_random((ph == 2) ? 40 : 160, ph == 3);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
